[hdl/sdi_capture_file_deframer_top_defines.svh]
// Assertion macros used by the deframer checker.
`ifndef SDI_CAPTURE_FILE_DEFRAMER_TOP_DEFINES_SVH
`define SDI_CAPTURE_FILE_DEFRAMER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SDICFD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdicfd checker: implication failed");

// Antecedent implies consequent in the next cycle.
`define SDICFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdicfd checker: next-cycle implication failed");

`endif

[hdl/sdicfd_pkg.sv]
// Package: types, constants and lookup tables of the SDI capture file deframer.
`timescale 1ns / 1ps
`default_nettype none
package sdicfd_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int          SIG_LEN        = 12;
  localparam logic [4:0]  POS_VERSION    = 5'd12;
  localparam logic [4:0]  POS_STANDARD   = 5'd13;
  localparam logic [4:0]  POS_FLAGS_LO   = 5'd14;
  localparam logic [4:0]  POS_SKIP_START = 5'd15;
  localparam logic [4:0]  POS_BODY       = 5'd16;
  localparam logic [4:0]  POS_SKIP_END   = 5'd23;
  localparam logic [15:0] FLAGS_REQUIRED = 16'h0101;
  localparam logic [7:0]  VERSION_MAX    = 8'd1;
  localparam logic [7:0]  VERSION_SKIP   = 8'd1;
  localparam logic [7:0]  ODD_MASK       = 8'h03;

  localparam logic [23:0] FB_625_864   = 24'(4 * 625 * 864);
  localparam logic [23:0] FB_525_858   = 24'(4 * 525 * 858);
  localparam logic [23:0] FB_750_1980  = 24'(4 * 750 * 1980);
  localparam logic [23:0] FB_750_1650  = 24'(4 * 750 * 1650);
  localparam logic [23:0] FB_1125_2750 = 24'(4 * 1125 * 2750);
  localparam logic [23:0] FB_1125_2640 = 24'(4 * 1125 * 2640);
  localparam logic [23:0] FB_1125_2200 = 24'(4 * 1125 * 2200);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_BODY   = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VIDEO  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // One classified item handed from front to back.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       odd;
    logic       last;
    logic [7:0] standard;
  } op_t;

  typedef struct packed {
    logic        known;
    logic [10:0] width;
    logic [10:0] height;
    logic [15:0] num;
    logic [9:0]  den;
    logic [23:0] frame_bytes;
  } std_info_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h44;
      4'd1:    b = 8'h65;
      4'd2:    b = 8'h6B;
      4'd3:    b = 8'h54;
      4'd4:    b = 8'h65;
      4'd5:    b = 8'h63;
      4'd6:    b = 8'h2E;
      4'd7:    b = 8'h64;
      4'd8:    b = 8'h74;
      4'd9:    b = 8'h73;
      4'd10:   b = 8'h64;
      4'd11:   b = 8'h69;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic std_info_t std_info(input logic [7:0] code);
    std_info_t e;
    e = '0;
    case (code)
      8'd1: e = '{1'b1, 11'd720, 11'd576, 16'd25, 10'd1, FB_625_864};
      8'd2: e = '{1'b1, 11'd720, 11'd480, 16'd30000, 10'd1001, FB_525_858};
      8'd8: e = '{1'b1, 11'd1280, 11'd720, 16'd50, 10'd1, FB_750_1980};
      8'd9: e = '{1'b1, 11'd1280, 11'd720, 16'd60000, 10'd1001, FB_750_1650};
      8'd11, 8'd22:
        e = '{1'b1, 11'd1920, 11'd1080, 16'd24000, 10'd1001, FB_1125_2750};
      8'd12, 8'd23:
        e = '{1'b1, 11'd1920, 11'd1080, 16'd24, 10'd1, FB_1125_2750};
      8'd13, 8'd16, 8'd24:
        e = '{1'b1, 11'd1920, 11'd1080, 16'd25, 10'd1, FB_1125_2640};
      8'd14, 8'd18, 8'd26:
        e = '{1'b1, 11'd1920, 11'd1080, 16'd30, 10'd1, FB_1125_2200};
      8'd15, 8'd17, 8'd25:
        e = '{1'b1, 11'd1920, 11'd1080, 16'd30000, 10'd1001, FB_1125_2200};
      8'd19: e = '{1'b1, 11'd1920, 11'd1080, 16'd50, 10'd1, FB_1125_2640};
      8'd20: e = '{1'b1, 11'd1920, 11'd1080, 16'd60000, 10'd1001, FB_1125_2200};
      8'd21: e = '{1'b1, 11'd1920, 11'd1080, 16'd60, 10'd1, FB_1125_2200};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

[hdl/sdicfd_if.sv]
// Interfaces: input byte channel and result channel of the deframer.
`timescale 1ns / 1ps
`default_nettype none
interface sdicfd_in_if;
  logic       valid;
  logic       ready;
  logic       stream_start;
  logic [7:0] data_byte;

  modport source (output valid, stream_start, data_byte, input ready);
  modport sink   (input valid, stream_start, data_byte, output ready);
endinterface

interface sdicfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  video_byte;
  logic        frame_end;
  logic [7:0]  standard;
  logic [10:0] active_width;
  logic [10:0] active_height;
  logic [15:0] rate_num;
  logic [9:0]  rate_den;
  logic [23:0] frame_bytes;

  modport source (output valid, kind, video_byte, frame_end, standard, active_width,
                  active_height, rate_num, rate_den, frame_bytes, input ready);
  modport sink   (input valid, kind, video_byte, frame_end, standard, active_width,
                  active_height, rate_num, rate_den, frame_bytes, output ready);
endinterface
`default_nettype wire

[hdl/sdi_capture_file_deframer_top.sv]
// SDI capture file deframer: parses the 16-byte header (plus 8 extra bytes for
// version 1), reports acceptance with the standard's active size, rate and frame
// length, then passes body bytes with odd bytes masked to two bits and the last
// byte of each frame marked; after a rejection bytes are dropped until the next
// stream start. One byte is accepted every clock while the queue has room. The
// front end classifies each byte in the cycle it is accepted and writes at most
// one item into a queue of QUEUE_DEPTH entries; the back end formats each item
// into the output register. din.ready falls only when the queue is full, which
// happens only while dout is stalled.
`timescale 1ns / 1ps
`default_nettype none
module sdi_capture_file_deframer_top
  import sdicfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  sdicfd_in_if.sink    din,
  sdicfd_out_if.source dout
);

  logic push, full, pop, q_valid;
  op_t  push_op, q_op;

  sdicfd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_full (full),
    .push   (push),
    .op     (push_op)
  );

  sdicfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  sdicfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .dout    (dout)
  );

endmodule
`default_nettype wire

[hdl/sdicfd_front.sv]
// Front end: header parser and byte classifier, one byte per clock while the queue is not full.
`timescale 1ns / 1ps
`default_nettype none
module sdicfd_front
  import sdicfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  sdicfd_in_if.sink din,
  input  logic  q_full,
  output logic  push,
  output op_t   op
);

  phase_t      phase, phase_next;
  logic [4:0]  header_pos, header_pos_next;
  logic        sig_ok, sig_ok_next;
  logic [7:0]  version, version_next;
  logic [7:0]  std_code, std_code_next;
  logic [7:0]  flags_lo, flags_lo_next;
  logic [23:0] frame_length, frame_length_next;
  logic [23:0] frame_pos, frame_pos_next;

  // State as seen by this byte: a start mark clears it first.
  phase_t      ph;
  logic [4:0]  hp;
  logic        sok;
  logic [7:0]  ver;
  logic [7:0]  stdc;
  logic [7:0]  flo;
  logic [23:0] flen;
  logic [23:0] fpos;

  logic        take;
  logic        last;
  logic        hdr_ok;
  logic [4:0]  hp_inc;
  std_info_t   info;

  assign din.ready = !q_full;
  assign take      = din.valid && din.ready;

  always_comb begin
    ph   = din.stream_start ? PH_HEADER : phase;
    hp   = din.stream_start ? '0 : header_pos;
    sok  = din.stream_start ? 1'b1 : sig_ok;
    ver  = din.stream_start ? '0 : version;
    stdc = din.stream_start ? '0 : std_code;
    flo  = din.stream_start ? '0 : flags_lo;
    flen = din.stream_start ? '0 : frame_length;
    fpos = din.stream_start ? '0 : frame_pos;

    hp_inc = hp + 5'd1;
    info   = std_info(stdc);
    last   = (flen != '0) && (({1'b0, fpos} + 25'd1) >= {1'b0, flen});
    hdr_ok = sok && (ver <= VERSION_MAX) && ({din.data_byte, flo} == FLAGS_REQUIRED)
             && info.known;

    phase_next        = ph;
    header_pos_next   = hp;
    sig_ok_next       = sok;
    version_next      = ver;
    std_code_next     = stdc;
    flags_lo_next     = flo;
    frame_length_next = flen;
    frame_pos_next    = fpos;
    push              = 1'b0;
    op                = '{KIND_VIDEO, din.data_byte, fpos[0], last, 8'd0};

    case (ph)
      PH_DROP: begin
      end
      PH_SKIP: begin
        header_pos_next = hp_inc;
        if (hp_inc >= POS_SKIP_END) begin
          phase_next     = PH_BODY;
          frame_pos_next = '0;
        end
      end
      PH_BODY: begin
        push           = take;
        frame_pos_next = last ? '0 : fpos + 24'd1;
      end
      PH_HEADER: begin
        if (hp < 5'(SIG_LEN)) begin
          if (din.data_byte != sig_byte(hp[3:0])) begin
            sig_ok_next = 1'b0;
          end
          header_pos_next = hp_inc;
        end else if (hp == POS_VERSION) begin
          version_next    = din.data_byte;
          header_pos_next = hp_inc;
        end else if (hp == POS_STANDARD) begin
          std_code_next   = din.data_byte;
          header_pos_next = hp_inc;
        end else if (hp == POS_FLAGS_LO) begin
          flags_lo_next   = din.data_byte;
          header_pos_next = hp_inc;
        end else begin
          // Last header byte: decide and report.
          push        = take;
          op.standard = stdc;
          op.kind     = hdr_ok ? KIND_ACCEPT : KIND_REJECT;
          if (!hdr_ok) begin
            phase_next = PH_DROP;
          end else begin
            frame_length_next = info.frame_bytes;
            frame_pos_next    = '0;
            if (ver == VERSION_SKIP) begin
              phase_next      = PH_SKIP;
              header_pos_next = POS_SKIP_START;
            end else begin
              phase_next      = PH_BODY;
              header_pos_next = POS_BODY;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_pos   <= '0;
      sig_ok       <= 1'b1;
      version      <= '0;
      std_code     <= '0;
      flags_lo     <= '0;
      frame_length <= '0;
      frame_pos    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      header_pos   <= header_pos_next;
      sig_ok       <= sig_ok_next;
      version      <= version_next;
      std_code     <= std_code_next;
      flags_lo     <= flags_lo_next;
      frame_length <= frame_length_next;
      frame_pos    <= frame_pos_next;
    end
  end

endmodule
`default_nettype wire

[hdl/sdicfd_queue.sv]
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sdicfd_queue
  import sdicfd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output op_t  q_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/sdicfd_back.sv]
// Back end: formats classified items into results and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module sdicfd_back
  import sdicfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  op_t  q_op,
  output logic pop,
  sdicfd_out_if.source dout
);

  logic        out_valid;
  kind_t       kind;
  logic [7:0]  video_byte;
  logic        frame_end;
  logic [7:0]  standard;
  std_info_t   info_reg;
  std_info_t   info;

  assign pop  = q_valid && (!out_valid || dout.ready);
  assign info = std_info(q_op.standard);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind       <= q_op.kind;
      video_byte <= '0;
      frame_end  <= 1'b0;
      standard   <= '0;
      info_reg   <= '0;
      case (q_op.kind)
        KIND_VIDEO: begin
          // Odd bytes carry the sample MSBs: keep two bits.
          video_byte <= q_op.odd ? (q_op.data & ODD_MASK) : q_op.data;
          frame_end  <= q_op.last;
        end
        KIND_ACCEPT: begin
          standard <= q_op.standard;
          info_reg <= info;
        end
        KIND_REJECT: begin
          standard <= q_op.standard;
        end
        default: begin
        end
      endcase
    end
  end

  assign dout.valid         = out_valid;
  assign dout.kind          = kind;
  assign dout.video_byte    = video_byte;
  assign dout.frame_end     = frame_end;
  assign dout.standard      = standard;
  assign dout.active_width  = info_reg.width;
  assign dout.active_height = info_reg.height;
  assign dout.rate_num      = info_reg.num;
  assign dout.rate_den      = info_reg.den;
  assign dout.frame_bytes   = info_reg.frame_bytes;

endmodule
`default_nettype wire

[hdl/sdicfd_checker.sv]
// Port-level checker for the deframer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sdi_capture_file_deframer_top_defines.svh"
module sdicfd_checker
  import sdicfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  video_byte,
  input logic        frame_end,
  input logic [7:0]  standard,
  input logic [10:0] active_width,
  input logic [9:0]  rate_den,
  input logic [23:0] frame_bytes
);

  `SDICFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SDICFD_ASSERT_IMPLY(a_video_clean, clk, rst, out_valid && kind == KIND_VIDEO,
    standard == 8'd0 && active_width == 11'd0 && frame_bytes == 24'd0)
  `SDICFD_ASSERT_IMPLY(a_accept_info, clk, rst, out_valid && kind == KIND_ACCEPT,
    frame_bytes != 24'd0 && (rate_den == 10'd1 || rate_den == 10'd1001) && !frame_end)
  `SDICFD_ASSERT_IMPLY(a_reject_clean, clk, rst, out_valid && kind == KIND_REJECT,
    video_byte == 8'd0 && !frame_end && frame_bytes == 24'd0 && active_width == 11'd0)

endmodule

bind sdi_capture_file_deframer_top sdicfd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .kind         (dout.kind),
  .video_byte   (dout.video_byte),
  .frame_end    (dout.frame_end),
  .standard     (dout.standard),
  .active_width (dout.active_width),
  .rate_den     (dout.rate_den),
  .frame_bytes  (dout.frame_bytes)
);
`default_nettype wire
